// ----- src/cbb_pkg.sv -----
// ----------------------------------------------------------------------------
// cbb_pkg
// shared widths, types and a helper function for the bezier bounding box unit
// ----------------------------------------------------------------------------
package cbb_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int T_FRAC_BITS = 16;

  // widths of the derivative coefficients
  localparam int CW = COORD_WIDTH + 2;  // unused; c and b are AW wide
  localparam int AW = COORD_WIDTH + 4;  // a, b, c
  localparam int HW = 2 * AW + 2;       // discriminant
  localparam int SW = HW / 2 + 1;       // square root
  localparam int NW = SW + 2;           // root numerator
  localparam int TW = T_FRAC_BITS + 1;  // t with a zero sign bit
  localparam int QW = AW + T_FRAC_BITS; // unused; the division partial remainder is AW wide
  localparam int EW = AW + 8;           // horner accumulator

  localparam int SQ_STEPS = SW;         // one result bit per stage
  localparam int DV_STEPS = T_FRAC_BITS;

  localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [AW-1:0] coef_t;

  // per axis word moving through the pipeline
  typedef struct packed {
    coord_t p0;
    coef_t  a;
    coef_t  b;
    coef_t  c;
    coord_t lo;
    coord_t hi;
    logic   go;
  } axis_t;

  function automatic logic signed [EW-1:0] rnd_shift(input logic signed [EW+TW-1:0] x);
    logic signed [EW+TW-1:0] y;
    begin
      y = x + (EW+TW)'(1 <<< (T_FRAC_BITS - 1));
      rnd_shift = EW'(y >>> T_FRAC_BITS);
    end
  endfunction

endpackage

// ----- src/cbb_sqrt.sv -----
// ----------------------------------------------------------------------------
// cbb_sqrt
// pipelined bit-by-bit integer square root by trial squaring, one result bit per stage
// ----------------------------------------------------------------------------
module cbb_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld_i,
  input  logic [cbb_pkg::HW-1:0]        h_i,
  input  cbb_pkg::axis_t                ax_i,
  input  cbb_pkg::axis_t                ay_i,
  input  logic [cbb_pkg::HW-1:0]        hy_i,
  output logic                          vld_o,
  output logic [cbb_pkg::SW-1:0]        sx_o,
  output logic [cbb_pkg::SW-1:0]        sy_o,
  output cbb_pkg::axis_t                ax_o,
  output cbb_pkg::axis_t                ay_o
);
  import cbb_pkg::*;

  logic           vld_r [SQ_STEPS+1];
  logic [HW-1:0]  hx_r  [SQ_STEPS+1];
  logic [HW-1:0]  hy_r  [SQ_STEPS+1];
  logic [SW-1:0]  rx_r  [SQ_STEPS+1];
  logic [SW-1:0]  ry_r  [SQ_STEPS+1];
  axis_t          ax_r  [SQ_STEPS+1];
  axis_t          ay_r  [SQ_STEPS+1];

  assign vld_r[0] = vld_i;
  assign hx_r[0]  = h_i;
  assign hy_r[0]  = hy_i;
  assign rx_r[0]  = '0;
  assign ry_r[0]  = '0;
  assign ax_r[0]  = ax_i;
  assign ay_r[0]  = ay_i;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_st
    localparam int BIT = SQ_STEPS - 1 - k;
    logic [SW-1:0]   cx, cy;
    logic [2*SW-1:0] qx, qy;
    assign cx = rx_r[k] | (SW'(1) << BIT);
    assign cy = ry_r[k] | (SW'(1) << BIT);
    assign qx = cx * cx;
    assign qy = cy * cy;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
      hx_r[k+1] <= hx_r[k];
      hy_r[k+1] <= hy_r[k];
      ax_r[k+1] <= ax_r[k];
      ay_r[k+1] <= ay_r[k];
      rx_r[k+1] <= ({{(2*SW-HW){1'b0}}, hx_r[k]} >= qx) ? cx : rx_r[k];
      ry_r[k+1] <= ({{(2*SW-HW){1'b0}}, hy_r[k]} >= qy) ? cy : ry_r[k];
    end
  end

  assign vld_o = vld_r[SQ_STEPS];
  assign sx_o  = rx_r[SQ_STEPS];
  assign sy_o  = ry_r[SQ_STEPS];
  assign ax_o  = ax_r[SQ_STEPS];
  assign ay_o  = ay_r[SQ_STEPS];
endmodule

// ----- src/cbb_root.sv -----
// ----------------------------------------------------------------------------
// cbb_root
// one root of one axis: pipelined divide for t, then horner evaluation
// ----------------------------------------------------------------------------
module cbb_root (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld_i,
  input  logic signed [cbb_pkg::NW-1:0] num_i,
  input  cbb_pkg::axis_t                ax_i,
  output logic                          vld_o,
  output logic                          hit_o,
  output cbb_pkg::coord_t               val_o,
  output cbb_pkg::axis_t                ax_o
);
  import cbb_pkg::*;

  localparam int NSTG = DV_STEPS + 4;

  // entry: qualify the root and take magnitudes
  logic          ok0;
  logic [NW-1:0] un;
  logic [AW-1:0] ua;
  always_comb begin
    un  = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
    ua  = ax_i.a[AW-1] ? AW'(-ax_i.a) : AW'(ax_i.a);
    ok0 = ax_i.go && (num_i != '0) && (num_i[NW-1] == ax_i.a[AW-1])
          && (un < {{(NW-AW){1'b0}}, ua});
  end

  logic          vld_r [DV_STEPS+1];
  logic          ok_r  [DV_STEPS+1];
  logic [AW-1:0] rem_r [DV_STEPS+1];
  logic [AW-1:0] ua_r  [DV_STEPS+1];
  logic [T_FRAC_BITS-1:0] q_r [DV_STEPS+1];
  axis_t         ax_r  [DV_STEPS+1];

  assign vld_r[0] = vld_i;
  assign ok_r[0]  = ok0;
  assign rem_r[0] = AW'(un);
  assign ua_r[0]  = ua;
  assign q_r[0]   = '0;
  assign ax_r[0]  = ax_i;

  for (genvar k = 0; k < DV_STEPS; k++) begin : g_dv
    logic [AW:0] sh;
    logic        ge;
    assign sh = {rem_r[k], 1'b0};
    assign ge = sh >= {1'b0, ua_r[k]};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
      ok_r[k+1]  <= ok_r[k];
      ua_r[k+1]  <= ua_r[k];
      ax_r[k+1]  <= ax_r[k];
      rem_r[k+1] <= ge ? AW'(sh - {1'b0, ua_r[k]}) : AW'(sh);
      q_r[k+1]   <= {q_r[k][T_FRAC_BITS-2:0], ge};
    end
  end

  // horner: three multiply stages and a final saturate stage
  logic signed [TW-1:0] t;
  assign t = $signed({1'b0, q_r[DV_STEPS]});

  logic          hv_r [4];
  logic          hk_r [4];
  logic signed [EW-1:0] acc_r [4];
  logic signed [TW-1:0] t_r [3];
  axis_t         hx_r [4];

  logic signed [EW+TW-1:0] m0, m1, m2;
  assign m0 = EW'(ax_r[DV_STEPS].a) * t;
  assign m1 = acc_r[0] * t_r[0];
  assign m2 = acc_r[1] * t_r[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r[0] <= 1'b0;
      hv_r[1] <= 1'b0;
      hv_r[2] <= 1'b0;
      hv_r[3] <= 1'b0;
    end else begin
      hv_r[0] <= vld_r[DV_STEPS];
      hv_r[1] <= hv_r[0];
      hv_r[2] <= hv_r[1];
      hv_r[3] <= hv_r[2];
    end
    hk_r[0]  <= ok_r[DV_STEPS] && (q_r[DV_STEPS] != '0);
    hk_r[1]  <= hk_r[0];
    hk_r[2]  <= hk_r[1];
    hk_r[3]  <= hk_r[2];
    t_r[0]   <= t;
    t_r[1]   <= t_r[0];
    t_r[2]   <= t_r[1];
    hx_r[0]  <= ax_r[DV_STEPS];
    hx_r[1]  <= hx_r[0];
    hx_r[2]  <= hx_r[1];
    hx_r[3]  <= hx_r[2];
    acc_r[0] <= rnd_shift(m0) + 3 * EW'(ax_r[DV_STEPS].b);
    acc_r[1] <= rnd_shift(m1) + 3 * EW'(hx_r[0].c);
    acc_r[2] <= rnd_shift(m2) + EW'(hx_r[1].p0);
    if (acc_r[2] > EW'(CMAX))      acc_r[3] <= EW'(CMAX);
    else if (acc_r[2] < EW'(CMIN)) acc_r[3] <= EW'(CMIN);
    else                           acc_r[3] <= acc_r[2];
  end

  assign vld_o = hv_r[3];
  assign hit_o = hk_r[3];
  assign val_o = COORD_WIDTH'(acc_r[3]);
  assign ax_o  = hx_r[3];
  logic unused;
  assign unused = ^t_r[2];
endmodule

// ----- src/cubic_bezier_bounding_box_unit.sv -----
// ----------------------------------------------------------------------------
// cubic_bezier_bounding_box_unit
// tight axis-aligned box of one cubic bezier curve per cycle
// ----------------------------------------------------------------------------
//  channel  ports        handshake
//  input    in_*         start high, busy low
//  result   out_*        out_valid strobe, one cycle
//
//  one word accepted each cycle; each box passes 3 coefficient and
//  discriminant stages, 30 square root bits, 16 quotient bits, 4 horner
//  stages and 1 merge stage
//  busy stays low; results cannot be stalled
//  synchronous reset clears all valid bits
module cubic_bezier_bounding_box_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  cbb_pkg::coord_t in_start_x,
  input  cbb_pkg::coord_t in_start_y,
  input  cbb_pkg::coord_t in_ctrl1_x,
  input  cbb_pkg::coord_t in_ctrl1_y,
  input  cbb_pkg::coord_t in_ctrl2_x,
  input  cbb_pkg::coord_t in_ctrl2_y,
  input  cbb_pkg::coord_t in_end_x,
  input  cbb_pkg::coord_t in_end_y,
  output logic            out_valid,
  output cbb_pkg::coord_t out_box_min_x,
  output cbb_pkg::coord_t out_box_min_y,
  output cbb_pkg::coord_t out_box_max_x,
  output cbb_pkg::coord_t out_box_max_y
);
  import cbb_pkg::*;

  assign busy = 1'b0;

  function automatic axis_t mk_axis(input coord_t p0, input coord_t p1,
                                    input coord_t p2, input coord_t p3);
    axis_t r;
    begin
      r.p0 = p0;
      r.c  = AW'(p1) - AW'(p0);
      r.b  = AW'(p0) - AW'(2) * AW'(p1) + AW'(p2);
      r.a  = -AW'(p0) + AW'(3) * AW'(p1) - AW'(3) * AW'(p2) + AW'(p3);
      r.lo = (p0 < p3) ? p0 : p3;
      r.hi = (p0 > p3) ? p0 : p3;
      r.go = 1'b1;
      mk_axis = r;
    end
  endfunction

  // stage 1: coefficients
  logic  v1_r;
  axis_t ax1_r, ay1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start;
    ax1_r <= mk_axis(in_start_x, in_ctrl1_x, in_ctrl2_x, in_end_x);
    ay1_r <= mk_axis(in_start_y, in_ctrl1_y, in_ctrl2_y, in_end_y);
  end

  // stage 2: products, stage 3: discriminant
  logic v2_r, v3_r;
  logic signed [HW-1:0] bbx_r, acx_r, bby_r, acy_r, hx_r, hy_r;
  axis_t ax2_r, ay2_r, ax3_r, ay3_r;
  axis_t ax3_nxt, ay3_nxt;

  always_comb begin
    ax3_nxt    = ax2_r;
    ay3_nxt    = ay2_r;
    ax3_nxt.go = (ax2_r.a != '0) && ((bbx_r - acx_r) > 0);
    ay3_nxt.go = (ay2_r.a != '0) && ((bby_r - acy_r) > 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    bbx_r <= HW'(ax1_r.b) * HW'(ax1_r.b);
    acx_r <= HW'(ax1_r.a) * HW'(ax1_r.c);
    bby_r <= HW'(ay1_r.b) * HW'(ay1_r.b);
    acy_r <= HW'(ay1_r.a) * HW'(ay1_r.c);
    ax2_r <= ax1_r;
    ay2_r <= ay1_r;
    hx_r  <= bbx_r - acx_r;
    hy_r  <= bby_r - acy_r;
    ax3_r <= ax3_nxt;
    ay3_r <= ay3_nxt;
  end

  logic          v4;
  logic [SW-1:0] sx, sy;
  axis_t         ax4, ay4;

  cbb_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (v3_r),
    .h_i   (hx_r[HW-1] ? '0 : hx_r),
    .ax_i  (ax3_r),
    .ay_i  (ay3_r),
    .hy_i  (hy_r[HW-1] ? '0 : hy_r),
    .vld_o (v4),
    .sx_o  (sx),
    .sy_o  (sy),
    .ax_o  (ax4),
    .ay_o  (ay4)
  );

  logic signed [NW-1:0] nx0, nx1, ny0, ny1;
  assign nx0 = -NW'(ax4.b) - NW'($signed({1'b0, sx}));
  assign nx1 = -NW'(ax4.b) + NW'($signed({1'b0, sx}));
  assign ny0 = -NW'(ay4.b) - NW'($signed({1'b0, sy}));
  assign ny1 = -NW'(ay4.b) + NW'($signed({1'b0, sy}));

  logic   rv [4];
  logic   rh [4];
  coord_t rval [4];
  axis_t  rax [4];

  cbb_root u_rx0 (.clk(clk), .rst_n(rst_n), .vld_i(v4), .num_i(nx0), .ax_i(ax4),
                  .vld_o(rv[0]), .hit_o(rh[0]), .val_o(rval[0]), .ax_o(rax[0]));
  cbb_root u_rx1 (.clk(clk), .rst_n(rst_n), .vld_i(v4), .num_i(nx1), .ax_i(ax4),
                  .vld_o(rv[1]), .hit_o(rh[1]), .val_o(rval[1]), .ax_o(rax[1]));
  cbb_root u_ry0 (.clk(clk), .rst_n(rst_n), .vld_i(v4), .num_i(ny0), .ax_i(ay4),
                  .vld_o(rv[2]), .hit_o(rh[2]), .val_o(rval[2]), .ax_o(rax[2]));
  cbb_root u_ry1 (.clk(clk), .rst_n(rst_n), .vld_i(v4), .num_i(ny1), .ax_i(ay4),
                  .vld_o(rv[3]), .hit_o(rh[3]), .val_o(rval[3]), .ax_o(rax[3]));

  // merge stage
  function automatic coord_t mn(input coord_t lo, input logic h0, input coord_t v0,
                                input logic h1, input coord_t v1);
    coord_t r;
    begin
      r = lo;
      if (h0 && v0 < r) r = v0;
      if (h1 && v1 < r) r = v1;
      mn = r;
    end
  endfunction

  function automatic coord_t mx(input coord_t hi, input logic h0, input coord_t v0,
                                input logic h1, input coord_t v1);
    coord_t r;
    begin
      r = hi;
      if (h0 && v0 > r) r = v0;
      if (h1 && v1 > r) r = v1;
      mx = r;
    end
  endfunction

  logic   vo_r;
  coord_t mnx_r, mny_r, mxx_r, mxy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else        vo_r <= rv[0] & rv[1] & rv[2] & rv[3];
    mnx_r <= mn(rax[0].lo, rh[0], rval[0], rh[1], rval[1]);
    mxx_r <= mx(rax[0].hi, rh[0], rval[0], rh[1], rval[1]);
    mny_r <= mn(rax[2].lo, rh[2], rval[2], rh[3], rval[3]);
    mxy_r <= mx(rax[2].hi, rh[2], rval[2], rh[3], rval[3]);
  end

  assign out_valid     = vo_r;
  assign out_box_min_x = mnx_r;
  assign out_box_min_y = mny_r;
  assign out_box_max_x = mxx_r;
  assign out_box_max_y = mxy_r;

  logic unused;
  assign unused = ^{rax[1], rax[3]};
endmodule

// ----- src/cbb_checker.sv -----
// ----------------------------------------------------------------------------
// cbb_checker
// port level checks on the bounding box unit
// ----------------------------------------------------------------------------
module cbb_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input logic            out_valid,
  input cbb_pkg::coord_t out_box_min_x,
  input cbb_pkg::coord_t out_box_min_y,
  input cbb_pkg::coord_t out_box_max_x,
  input cbb_pkg::coord_t out_box_max_y
);
  a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
  a_ordx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_box_min_x <= out_box_max_x) else $error("x box inverted");
  a_ordy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_box_min_y <= out_box_max_y) else $error("y box inverted");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("word after reset");
  logic unused;
  assign unused = start;
endmodule

bind cubic_bezier_bounding_box_unit cbb_checker u_cbb_checker (.*);
